/* design/bdq_pkg.sv */
// Shared types, command and status codes for the bounded deque core.
package bdq_pkg;

  // Default sizing
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DROP_BACK  = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  // Per-cycle control broadcast along one chain of cells
  typedef struct packed {
    logic insert;   // shift toward the tail, new value enters at the head cell
    logic remove;   // shift toward the head, head entry leaves
    logic append;   // write new value in the cell just past the last entry
  } cell_ctrl_t;

endpackage

/* design/bdq_cell.sv */
// One storage cell of a deque chain; trades data with its two neighbors.
module bdq_cell #(
  parameter int STORE_W = 32,
  parameter int CNT_W   = 5,
  parameter int INDEX   = 0
) (
  input  logic                clk,
  input  bdq_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    count,
  input  logic [STORE_W-1:0]  value,
  input  logic [STORE_W-1:0]  head_side_data,
  input  logic [STORE_W-1:0]  tail_side_data,
  output logic [STORE_W-1:0]  data_r,
  output logic [STORE_W-1:0]  data_nxt
);

  // Next content of this cell
  always_comb begin
    data_nxt = data_r;
    if (ctrl.insert) begin
      data_nxt = head_side_data;
    end else if (ctrl.remove) begin
      data_nxt = tail_side_data;
    end else if (ctrl.append && (count == CNT_W'(INDEX))) begin
      data_nxt = value;
    end
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

/* design/bdq_chain.sv */
// Row of deque cells with the head at cell zero; reports the next head value.
module bdq_chain #(
  parameter int CAPACITY = bdq_pkg::CAPACITY_DEF,
  parameter int STORE_W  = 32,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  bdq_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    count,
  input  logic [STORE_W-1:0]  value,
  output logic [STORE_W-1:0]  head_nxt
);

  logic [STORE_W-1:0] cell_data [CAPACITY];
  logic [STORE_W-1:0] cell_next [CAPACITY];

  // Cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [STORE_W-1:0] head_side;
    logic [STORE_W-1:0] tail_side;

    if (i == 0) begin : g_head
      assign head_side = value;
    end else begin : g_mid
      assign head_side = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign tail_side = cell_data[i];
    end else begin : g_body
      assign tail_side = cell_data[i+1];
    end

    bdq_cell #(
      .STORE_W(STORE_W),
      .CNT_W  (CNT_W),
      .INDEX  (i)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .count         (count),
      .value         (value),
      .head_side_data(head_side),
      .tail_side_data(tail_side),
      .data_r        (cell_data[i]),
      .data_nxt      (cell_next[i])
    );
  end

  assign head_nxt = cell_next[0];

endmodule

/* design/bounded_deque_core.sv */
// Bounded double-ended queue: top level with two cell chains and the result register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_cmd / in_value) carries one
//   command per transaction: push front, push back, drop front, drop back.
//   Result channel (out_valid / out_stall / out_*) returns exactly one
//   transaction per command: status, entry count after the step, and the
//   front and back values after the step (zero when the queue is empty).
//   Entries live in two rows of cells: one keeps the front at its head
//   cell, the other keeps the back at its head cell, so both ends are
//   always at fixed places and every step is a single shift or write.
//   Latency: the result is registered and shows the cycle after the
//   command is taken. Throughput: one command per cycle while the result
//   side keeps up; in_stall rises only when a result is held and
//   out_stall is high, and the held result stays until taken.
//   Reset (rst_n low, synchronous) empties the queue and drops any
//   pending result; store contents are not cleared and need no sweep.
//   Drops on an empty queue and pushes on a full queue change nothing
//   and report their status.
module bounded_deque_core #(
  parameter int CAPACITY   = bdq_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bdq_pkg::CMD_W-1:0]    in_cmd,
  input  logic signed [bdq_pkg::VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bdq_pkg::STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]             out_entry_count,
  output logic signed [bdq_pkg::VALUE_W-1:0] out_front_value,
  output logic signed [bdq_pkg::VALUE_W-1:0] out_back_value
);

  localparam int STORE_W = (DATA_WIDTH < bdq_pkg::VALUE_W) ? DATA_WIDTH : bdq_pkg::VALUE_W;
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  logic                         out_valid_r;
  logic [bdq_pkg::STATUS_W-1:0] status_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [bdq_pkg::VALUE_W-1:0]  front_r, back_r;

  logic                         in_fire, out_fire;
  logic                         is_full, is_empty;
  logic                         do_push_front, do_push_back, do_drop_front, do_drop_back;
  logic [bdq_pkg::STATUS_W-1:0] status_nxt;
  bdq_pkg::cell_ctrl_t          front_ctrl, back_ctrl;
  logic [STORE_W-1:0]           store_value;
  logic [STORE_W-1:0]           front_head_nxt, back_head_nxt;
  logic [bdq_pkg::VALUE_W-1:0]  front_ext, back_ext;

  // Handshake
  assign out_fire = out_valid_r && !out_stall;
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign is_full     = (count_r == FULL_COUNT);
  assign is_empty    = (count_r == '0);
  assign store_value = in_value[STORE_W-1:0];

  // Command decode
  always_comb begin
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_drop_front = 1'b0;
    do_drop_back  = 1'b0;
    status_nxt    = bdq_pkg::STAT_DONE;
    unique case (in_cmd)
      bdq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) status_nxt = bdq_pkg::STAT_FULL;
        else         do_push_front = in_fire;
      end
      bdq_pkg::CMD_PUSH_BACK: begin
        if (is_full) status_nxt = bdq_pkg::STAT_FULL;
        else         do_push_back = in_fire;
      end
      bdq_pkg::CMD_DROP_FRONT: begin
        if (is_empty) status_nxt = bdq_pkg::STAT_EMPTY;
        else          do_drop_front = in_fire;
      end
      bdq_pkg::CMD_DROP_BACK: begin
        if (is_empty) status_nxt = bdq_pkg::STAT_EMPTY;
        else          do_drop_back = in_fire;
      end
      default: status_nxt = bdq_pkg::STAT_DONE;
    endcase
  end

  // Count update
  always_comb begin
    count_nxt = count_r;
    if (do_push_front || do_push_back) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_drop_front || do_drop_back) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Chain controls: front chain has the front at cell zero, back chain the back
  assign front_ctrl.insert = do_push_front;
  assign front_ctrl.remove = do_drop_front;
  assign front_ctrl.append = do_push_back;
  assign back_ctrl.insert  = do_push_back;
  assign back_ctrl.remove  = do_drop_back;
  assign back_ctrl.append  = do_push_front;

  bdq_chain #(
    .CAPACITY(CAPACITY),
    .STORE_W (STORE_W),
    .CNT_W   (CNT_W)
  ) u_front_chain (
    .clk     (clk),
    .ctrl    (front_ctrl),
    .count   (count_r),
    .value   (store_value),
    .head_nxt(front_head_nxt)
  );

  bdq_chain #(
    .CAPACITY(CAPACITY),
    .STORE_W (STORE_W),
    .CNT_W   (CNT_W)
  ) u_back_chain (
    .clk     (clk),
    .ctrl    (back_ctrl),
    .count   (count_r),
    .value   (store_value),
    .head_nxt(back_head_nxt)
  );

  // Zero-extend stored values, zero when empty
  always_comb begin
    front_ext = '0;
    back_ext  = '0;
    if (count_nxt != '0) begin
      front_ext[STORE_W-1:0] = front_head_nxt;
      back_ext[STORE_W-1:0]  = back_head_nxt;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      front_r  <= front_ext;
      back_r   <= back_ext;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_count = count_r;
  assign out_front_value = front_r;
  assign out_back_value  = back_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("entry count above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push_front || do_push_back) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow the count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && count_r == '0) |-> (front_r == '0 && back_r == '0))
    else $error("empty queue reports nonzero ends");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == bdq_pkg::STAT_FULL) |-> count_r == FULL_COUNT)
    else $error("full status while not full");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(count_r))
    else $error("count changed without a transaction");

endmodule
